// ===== design/btpm_pkg.sv =====
// Shared types and constants for the binary trie prefix match block.
// No dependencies; imported by binary_trie_prefix_match and btpm_checker.
package btpm_pkg;

    localparam int NODE_COUNT_DEF = 1024;
    localparam int ADDR_BITS_DEF  = 32;

    localparam int FUNC_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int PLEN_W   = 6;
    localparam int HOP_W    = 16;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD      = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } t_state;

endpackage

// ===== design/binary_trie_prefix_match.sv =====
// Longest-prefix-match table as a one-bit trie in a node RAM; top level.
// Depends on btpm_pkg and btpm_ram.
//
//  channel  dir  tdata                                    tuser
//  s_axis   in   addr[31:0] prefix_len[37:32] hop[53:38]  func[1:0]
//  m_axis   out  hop_out[15:0]                            status[1:0]
//
// One request walks one trie level per cycle: the registered node RAM read
// feeds the child index straight into the next read address.
// Reset is synchronous; the root entry reads empty until first written.
// Requests are taken only between walks; a result waits in the output
// register while the next request is taken and walked.
module binary_trie_prefix_match
    import btpm_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // addr, prefix_len, hop_in, zero pad
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // func
    input  logic [FUNC_W-1:0]    i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // hop_out
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]  o_m_axis_tuser
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int NODE_W = HOP_W + 2 * IDX_W;
    localparam int FREE_W = IDX_W + 1;
    localparam int LVL_W  = $clog2(ADDR_BITS + 1);
    localparam int CMP_W  = (LVL_W > PLEN_W + 1) ? LVL_W : PLEN_W + 1;

    t_state              r_state, n_state;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [ADDR_BITS-1:0] r_path, n_path;
    logic [LVL_W-1:0]    r_plen, n_plen;
    logic [HOP_W-1:0]    r_hop_in, n_hop_in;
    logic [IDX_W-1:0]    r_node, n_node;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic                r_fresh, n_fresh;
    logic [FREE_W-1:0]   r_free, n_free;
    logic                r_root_valid, n_root_valid;
    logic [HOP_W-1:0]    r_res_hop, n_res_hop;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic                r_o_valid, n_o_valid;
    logic [HOP_W-1:0]    r_o_hop, n_o_hop;
    logic [STATUS_W-1:0] r_o_status, n_o_status;

    logic [ADDR_W-1:0]    in_addr;
    logic [PLEN_W-1:0]    in_plen;
    logic [HOP_W-1:0]     in_hop;
    logic [ADDR_BITS-1:0] in_path;
    logic [CMP_W-1:0]     plen_ext;
    logic [CMP_W-1:0]     plen_sat;

    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [NODE_W-1:0] mem_wdata, mem_rdata;

    logic [NODE_W-1:0] cur;
    logic [HOP_W-1:0]  cur_hop;
    logic [IDX_W-1:0]  cur_kid0, cur_kid1, cur_kid;
    logic              path_bit;
    logic [LVL_W-1:0]  lvl_limit;
    logic              at_end;
    logic              pool_full;
    logic              in_accept;

    assign in_addr = i_s_axis_tdata[ADDR_W-1:0];
    assign in_plen = i_s_axis_tdata[ADDR_W +: PLEN_W];
    assign in_hop  = i_s_axis_tdata[ADDR_W + PLEN_W +: HOP_W];

    // address bits above bit 31 read as zero
    for (genvar g = 0; g < ADDR_BITS; g++) begin : g_path
        if (g < ADDR_W) begin : g_bit
            assign in_path[g] = in_addr[g];
        end else begin : g_zero
            assign in_path[g] = 1'b0;
        end
    end

    assign plen_ext = CMP_W'(in_plen);
    assign plen_sat = (plen_ext > CMP_W'(ADDR_BITS)) ? CMP_W'(ADDR_BITS) : plen_ext;

    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);

    // fresh nodes and an unwritten root read as empty
    assign cur = (r_fresh || (r_node == '0 && !r_root_valid)) ? '0 : mem_rdata;
    assign cur_hop  = cur[HOP_W-1:0];
    assign cur_kid0 = cur[HOP_W +: IDX_W];
    assign cur_kid1 = cur[HOP_W + IDX_W +: IDX_W];
    assign path_bit = r_path[ADDR_BITS-1];
    assign cur_kid  = path_bit ? cur_kid1 : cur_kid0;

    assign lvl_limit = (r_func == FUNC_LOOKUP) ? LVL_W'(ADDR_BITS) : r_plen;
    assign at_end    = (r_lvl == lvl_limit);
    assign pool_full = (r_free >= FREE_W'(NODE_COUNT));

    btpm_ram #(
        .WIDTH(NODE_W),
        .DEPTH(NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_path       = r_path;
        n_plen       = r_plen;
        n_hop_in     = r_hop_in;
        n_node       = r_node;
        n_lvl        = r_lvl;
        n_fresh      = r_fresh;
        n_free       = r_free;
        n_res_hop    = r_res_hop;
        n_res_status = r_res_status;
        n_o_hop      = r_o_hop;
        n_o_status   = r_o_status;
        n_o_valid    = r_o_valid && !i_m_axis_tready;
        mem_we       = 1'b0;
        mem_waddr    = r_node;
        mem_wdata    = cur;
        mem_re       = 1'b0;
        mem_raddr    = cur_kid;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_func       = i_s_axis_tuser;
                    n_path       = in_path;
                    n_plen       = LVL_W'(plen_sat);
                    n_hop_in     = in_hop;
                    n_node       = '0;
                    n_lvl        = '0;
                    n_fresh      = 1'b0;
                    n_res_hop    = '0;
                    n_res_status = STATUS_OK;
                    if (i_s_axis_tuser == FUNC_NONE) begin
                        n_state = ST_FIN;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        n_state   = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                case (r_func)
                    FUNC_LOOKUP: begin
                        if (cur_hop != '0) begin
                            n_res_hop = cur_hop;
                        end
                        if (at_end || cur_kid == '0) begin
                            n_state = ST_FIN;
                        end else begin
                            mem_re  = 1'b1;
                            n_node  = cur_kid;
                            n_lvl   = r_lvl + 1'b1;
                            n_path  = {r_path[ADDR_BITS-2:0], 1'b0};
                        end
                    end
                    FUNC_INSERT: begin
                        if (at_end) begin
                            mem_we    = 1'b1;
                            mem_wdata = {cur_kid1, cur_kid0, r_hop_in};
                            n_state   = ST_FIN;
                        end else if (cur_kid != '0) begin
                            mem_re  = 1'b1;
                            n_node  = cur_kid;
                            n_lvl   = r_lvl + 1'b1;
                            n_path  = {r_path[ADDR_BITS-2:0], 1'b0};
                        end else if (pool_full) begin
                            // a node created on this walk still needs its empty image
                            mem_we       = r_fresh;
                            n_res_status = STATUS_FULL;
                            n_state      = ST_FIN;
                        end else begin
                            mem_we = 1'b1;
                            if (path_bit) begin
                                mem_wdata = {r_free[IDX_W-1:0], cur_kid0, cur_hop};
                            end else begin
                                mem_wdata = {cur_kid1, r_free[IDX_W-1:0], cur_hop};
                            end
                            n_node  = r_free[IDX_W-1:0];
                            n_free  = r_free + 1'b1;
                            n_fresh = 1'b1;
                            n_lvl   = r_lvl + 1'b1;
                            n_path  = {r_path[ADDR_BITS-2:0], 1'b0};
                        end
                    end
                    FUNC_DELETE: begin
                        if (at_end) begin
                            if (cur_hop == '0) begin
                                n_res_status = STATUS_NOTFOUND;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = {cur_kid1, cur_kid0, {HOP_W{1'b0}}};
                            end
                            n_state = ST_FIN;
                        end else if (cur_kid == '0) begin
                            n_res_status = STATUS_NOTFOUND;
                            n_state      = ST_FIN;
                        end else begin
                            mem_re  = 1'b1;
                            n_node  = cur_kid;
                            n_lvl   = r_lvl + 1'b1;
                            n_path  = {r_path[ADDR_BITS-2:0], 1'b0};
                        end
                    end
                    default: begin
                        n_state = ST_FIN;
                    end
                endcase
            end
            ST_FIN: begin
                if (!r_o_valid || i_m_axis_tready) begin
                    n_o_valid  = 1'b1;
                    n_o_hop    = r_res_hop;
                    n_o_status = r_res_status;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_root_valid = r_root_valid || (mem_we && mem_waddr == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_free       <= FREE_W'(1);
            r_root_valid <= 1'b0;
            r_o_valid    <= 1'b0;
            r_fresh      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free       <= n_free;
            r_root_valid <= n_root_valid;
            r_o_valid    <= n_o_valid;
            r_fresh      <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_path       <= n_path;
        r_plen       <= n_plen;
        r_hop_in     <= n_hop_in;
        r_node       <= n_node;
        r_lvl        <= n_lvl;
        r_res_hop    <= n_res_hop;
        r_res_status <= n_res_status;
        r_o_hop      <= n_o_hop;
        r_o_status   <= n_o_status;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_hop;
    assign o_m_axis_tuser  = r_o_status;

endmodule

// ===== design/btpm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module btpm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/btpm_checker.sv =====
// Port-level assertions for binary_trie_prefix_match, with the bind statement.
// Depends on btpm_pkg.
module btpm_checker
    import btpm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [STATUS_W-1:0]  o_m_axis_tuser
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped before taken");

    // one request in flight at a time
    a_one_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken during a walk");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser != STATUS_BAD)
        else $error("undefined status code");

    // failures come only from insert or delete, which report no hop
    a_fail_no_hop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != STATUS_OK |-> o_m_axis_tdata == '0)
        else $error("hop reported with a failure status");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind binary_trie_prefix_match btpm_checker u_btpm_checker (.*);
